// ===== rtl/core/rosf_pkg.sv =====
// ----------------------------------------------------------------------------
// rosf_pkg
// Shared types and constants of the running order statistic smoother.
// ----------------------------------------------------------------------------
`default_nettype none

package rosf_pkg;

  localparam int SAMPLE_BITS       = 16;
  localparam int WINDOW_DEPTH_DEF  = 32;
  localparam int SPAN_BITS         = 5;
  localparam int KEEP_BITS         = 6;
  localparam int MODE_BITS         = 2;
  localparam int CFG_ADDR_BITS     = 2;
  localparam int CFG_DATA_BITS     = 6;

  localparam logic [SPAN_BITS-1:0] SPAN_RESET = 5'd4;
  localparam logic [KEEP_BITS-1:0] KEEP_RESET = 6'd5;

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    REG_WINDOW_SPAN = 2'd0,
    REG_KEEP_COUNT  = 2'd1,
    REG_MODE        = 2'd2
  } cfg_reg_t;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_MEDIAN = 2'd0,
    MODE_MEAN   = 2'd1,
    MODE_MIN    = 2'd2,
    MODE_MAX    = 2'd3
  } smooth_mode_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_CLEAR  = 2'd1,
    CELL_INSERT = 2'd2,
    CELL_SHIFT  = 2'd3
  } cell_op_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          final_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] smoothed;
    logic                          record_done;
  } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/core/rosf_cell.sv =====
// ----------------------------------------------------------------------------
// rosf_cell
// One slot of the insertion sorting chain.
// ----------------------------------------------------------------------------
`default_nettype none

module rosf_cell (
  input  wire                                     clk,
  input  wire                                     rst_n,
  input  rosf_pkg::cell_op_t                      op,
  input  wire signed [rosf_pkg::SAMPLE_BITS-1:0]  key,
  input  wire signed [rosf_pkg::SAMPLE_BITS-1:0]  prev_val,
  input  wire                                     prev_gt,
  input  wire                                     prev_occ,
  input  wire signed [rosf_pkg::SAMPLE_BITS-1:0]  next_val,
  output logic signed [rosf_pkg::SAMPLE_BITS-1:0] val,
  output logic                                    gt,
  output logic                                    occ
);
  import rosf_pkg::*;

  logic signed [SAMPLE_BITS-1:0] val_r, val_nxt;
  logic                          occ_r, occ_nxt;

  // An empty slot acts as larger than any key.
  assign gt  = !occ_r || (val_r > key);
  assign val = val_r;
  assign occ = occ_r;

  always_comb begin
    val_nxt = val_r;
    occ_nxt = occ_r;
    case (op)
      CELL_CLEAR: begin
        occ_nxt = 1'b0;
      end
      CELL_INSERT: begin
        if (gt) begin
          val_nxt = prev_gt ? prev_val : key;
        end
        occ_nxt = occ_r | prev_occ;
      end
      CELL_SHIFT: begin
        val_nxt = next_val;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/rosf_divider.sv =====
// ----------------------------------------------------------------------------
// rosf_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rosf_divider #(
  parameter int DW = 22
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               start,
  input  wire [DW-1:0]                      dividend,
  input  wire [rosf_pkg::KEEP_BITS-1:0]     divisor,
  output logic                              done,
  output logic [DW-1:0]                     quotient
);
  import rosf_pkg::*;

  localparam int CNT_W = $clog2(DW + 1);

  logic [KEEP_BITS:0]   rem_r, rem_nxt;
  logic [DW-1:0]        quo_r, quo_nxt;
  logic [KEEP_BITS-1:0] dvs_r;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt, done_r, done_nxt;
  logic [KEEP_BITS+1:0] trial;

  assign trial    = {rem_r, quo_r[DW-1]} - {2'b00, dvs_r};
  assign done     = done_r;
  assign quotient = quo_r;

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = CNT_W'(DW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[KEEP_BITS+1]) begin
        rem_nxt = trial[KEEP_BITS:0];
        quo_nxt = {quo_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[KEEP_BITS-1:0], quo_r[DW-1]};
        quo_nxt = {quo_r[DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/running_order_statistic_smoother.sv =====
// ----------------------------------------------------------------------------
// running_order_statistic_smoother
// Each result runs through clear, sort (window inserted), drain (kept values
// read out), finish, divide in mean mode, and out. The final beat of a record
// repeats this for each pending position (up to look-ahead+1 results).
// One input beat is taken at a time; chain, divider and out_ready set the rate.
// Reset is synchronous, active low; registers return to span 4, keep 5, median.
// ----------------------------------------------------------------------------
`default_nettype none

module running_order_statistic_smoother #(
  parameter int WINDOW_DEPTH = rosf_pkg::WINDOW_DEPTH_DEF
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   in_valid,
  output logic                                  in_ready,
  input  rosf_pkg::in_item_t                    in_data,
  output logic                                  out_valid,
  input  wire                                   out_ready,
  output rosf_pkg::out_item_t                   out_data,
  input  wire                                   cfg_we,
  input  wire [rosf_pkg::CFG_ADDR_BITS-1:0]     cfg_addr,
  input  wire [rosf_pkg::CFG_DATA_BITS-1:0]     cfg_wdata
);
  import rosf_pkg::*;

  // Counter width: holds the depth itself and at least a 6-bit keep count.
  localparam int CNT_BITS = $clog2(WINDOW_DEPTH + 1);
  localparam int CW       = (CNT_BITS > 6) ? CNT_BITS : 6;
  localparam int IDX_W    = $clog2(WINDOW_DEPTH);
  localparam int SUM_W    = SAMPLE_BITS + 6;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CLEAR, ST_SORT, ST_DRAIN, ST_FINISH, ST_DIVIDE, ST_OUT
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [SPAN_BITS-1:0] span_r;
  logic [KEEP_BITS-1:0] keep_r;
  smooth_mode_t         mode_r;

  // History: a shift line, entry 0 holds the newest sample.
  logic signed [SAMPLE_BITS-1:0] hist_r [WINDOW_DEPTH];
  logic [CW-1:0]                 seen_r, seen_nxt;

  // Per-result control.
  logic [CW-1:0] c_r, c_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic          last_r, last_nxt;

  // Drain captures and accumulation.
  logic signed [SAMPLE_BITS-1:0] lo_r, hi_r, mn_r, mx_r;
  logic signed [SUM_W-1:0]       sum_r;
  logic                          neg_r;

  logic                          out_valid_r, out_valid_nxt;
  out_item_t                     out_data_r, out_data_nxt;

  // Effective window geometry, from the registers.
  logic [CW-1:0] span_ext, span_eff, n_eff, half, look, keep_ext, m_eff;

  always_comb begin
    span_ext = CW'(span_r);
    if (span_ext == '0) begin
      span_eff = CW'(1);
    end else if (span_ext > CW'(WINDOW_DEPTH - 1)) begin
      span_eff = CW'(WINDOW_DEPTH - 1);
    end else begin
      span_eff = span_ext;
    end
    n_eff    = span_eff + 1'b1;
    half     = span_eff >> 1;
    look     = span_eff - half;
    keep_ext = CW'(keep_r);
    if (keep_ext == '0) begin
      m_eff = CW'(1);
    end else if (keep_ext > n_eff) begin
      m_eff = n_eff;
    end else begin
      m_eff = keep_ext;
    end
  end

  // Window element j sits c + half - j samples back from the newest one,
  // limited to the samples of the current record.
  logic signed [CW+1:0]          back_raw;
  logic [CW-1:0]                 dist_c;
  logic signed [SAMPLE_BITS-1:0] win_val;

  always_comb begin
    back_raw = $signed({2'b00, c_r}) + $signed({2'b00, half}) - $signed({2'b00, j_r});
    if (back_raw < 0) begin
      dist_c = '0;
    end else if (back_raw[CW-1:0] > seen_r - 1'b1 || back_raw[CW] || back_raw[CW+1]) begin
      dist_c = seen_r - 1'b1;
    end else begin
      dist_c = back_raw[CW-1:0];
    end
    win_val = hist_r[dist_c[IDX_W-1:0]];
  end

  // The sorting chain. Values enter by parallel insertion and leave toward
  // cell 0, one per cycle, in ascending order.
  cell_op_t                      cell_op;
  logic signed [SAMPLE_BITS-1:0] cell_val [WINDOW_DEPTH];
  logic                          cell_gt  [WINDOW_DEPTH];
  logic                          cell_occ [WINDOW_DEPTH];

  always_comb begin
    case (state_r)
      ST_CLEAR: cell_op = CELL_CLEAR;
      ST_SORT:  cell_op = CELL_INSERT;
      ST_DRAIN: cell_op = CELL_SHIFT;
      default:  cell_op = CELL_HOLD;
    endcase
  end

  for (genvar g = 0; g < WINDOW_DEPTH; g++) begin : g_cell
    rosf_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .op       (cell_op),
      .key      (win_val),
      .prev_val ((g == 0) ? win_val : cell_val[(g == 0) ? 0 : g - 1]),
      .prev_gt  ((g == 0) ? 1'b0 : cell_gt[(g == 0) ? 0 : g - 1]),
      .prev_occ ((g == 0) ? 1'b1 : cell_occ[(g == 0) ? 0 : g - 1]),
      .next_val (cell_val[(g == WINDOW_DEPTH - 1) ? g : g + 1]),
      .val      (cell_val[g]),
      .gt       (cell_gt[g]),
      .occ      (cell_occ[g])
    );
  end

  // Mean: magnitude of the sum divided by the kept count.
  logic                  div_start, div_done;
  logic [SUM_W-1:0]      div_q;
  logic [SUM_W-1:0]      sum_mag;

  assign sum_mag   = sum_r[SUM_W-1] ? (~sum_r + 1'b1) : sum_r;
  assign div_start = (state_r == ST_FINISH) && (mode_r == MODE_MEAN);

  rosf_divider #(.DW(SUM_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_mag),
    .divisor  (m_eff[KEEP_BITS-1:0]),
    .done     (div_done),
    .quotient (div_q)
  );

  // Accept-time bookkeeping.
  logic          in_fire, out_fire;
  logic [CW-1:0] seen_inc, seen_m1;
  logic signed [SAMPLE_BITS:0] pair_sum;
  logic [SUM_W-1:0]            mean_v;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid_r && out_ready;
  assign seen_inc = (seen_r < CW'(WINDOW_DEPTH)) ? seen_r + 1'b1 : seen_r;
  assign seen_m1  = seen_inc - 1'b1;
  assign pair_sum = {lo_r[SAMPLE_BITS-1], lo_r} + {hi_r[SAMPLE_BITS-1], hi_r};
  assign mean_v   = neg_r ? (~div_q + 1'b1) : div_q;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    seen_nxt      = seen_r;
    c_nxt         = c_r;
    j_nxt         = j_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          seen_nxt = seen_inc;
          last_nxt = in_data.final_sample;
          if (in_data.final_sample) begin
            c_nxt     = (seen_m1 > look) ? look : seen_m1;
            state_nxt = ST_CLEAR;
          end else if (seen_m1 >= look) begin
            c_nxt     = look;
            state_nxt = ST_CLEAR;
          end
        end
      end
      ST_CLEAR: begin
        j_nxt     = '0;
        state_nxt = ST_SORT;
      end
      ST_SORT: begin
        j_nxt = j_r + 1'b1;
        if (j_r == span_eff) begin
          j_nxt     = '0;
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        j_nxt = j_r + 1'b1;
        if (j_r == m_eff - 1'b1) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        out_data_nxt.record_done = last_r && (c_r == '0);
        case (mode_r)
          MODE_MEDIAN: begin
            out_data_nxt.smoothed = m_eff[0] ? lo_r : pair_sum[SAMPLE_BITS:1];
            out_valid_nxt         = 1'b1;
            state_nxt             = ST_OUT;
          end
          MODE_MIN: begin
            out_data_nxt.smoothed = mn_r;
            out_valid_nxt         = 1'b1;
            state_nxt             = ST_OUT;
          end
          MODE_MAX: begin
            out_data_nxt.smoothed = mx_r;
            out_valid_nxt         = 1'b1;
            state_nxt             = ST_OUT;
          end
          default: begin
            state_nxt = ST_DIVIDE;
          end
        endcase
      end
      ST_DIVIDE: begin
        if (div_done) begin
          out_data_nxt.smoothed = mean_v[SAMPLE_BITS-1:0];
          out_valid_nxt         = 1'b1;
          state_nxt             = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_fire) begin
          out_valid_nxt = 1'b0;
          if (last_r && c_r != '0) begin
            c_nxt     = c_r - 1'b1;
            state_nxt = ST_CLEAR;
          end else begin
            if (last_r) begin
              seen_nxt = '0;
            end
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    // Payload registers.
    out_data_r <= out_data_nxt;
    c_r        <= c_nxt;
    j_r        <= j_nxt;
    last_r     <= last_nxt;
    if (in_fire) begin
      hist_r[0] <= in_data.sample;
      for (int i = 1; i < WINDOW_DEPTH; i++) begin
        hist_r[i] <= hist_r[i-1];
      end
    end
    if (state_r == ST_CLEAR) begin
      sum_r <= '0;
    end else if (state_r == ST_DRAIN) begin
      sum_r <= sum_r + SUM_W'(cell_val[0]);
      if (j_r == ((m_eff - 1'b1) >> 1)) lo_r <= cell_val[0];
      if (j_r == (m_eff >> 1))          hi_r <= cell_val[0];
      if (j_r == '0)                    mn_r <= cell_val[0];
      if (j_r == m_eff - 1'b1)          mx_r <= cell_val[0];
    end
    if (div_start) begin
      neg_r <= sum_r[SUM_W-1];
    end
    // Control state.
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      seen_r      <= '0;
      out_valid_r <= 1'b0;
      span_r      <= SPAN_RESET;
      keep_r      <= KEEP_RESET;
      mode_r      <= MODE_MEDIAN;
    end else begin
      state_r     <= state_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          REG_WINDOW_SPAN: span_r <= cfg_wdata[SPAN_BITS-1:0];
          REG_KEEP_COUNT:  keep_r <= cfg_wdata[KEEP_BITS-1:0];
          REG_MODE:        mode_r <= smooth_mode_t'(cfg_wdata[MODE_BITS-1:0]);
          default: begin
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/rosf_checker.sv =====
// ----------------------------------------------------------------------------
// rosf_checker
// Port-level checks of the smoother, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rosf_checker (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 in_ready,
  input wire                 out_valid,
  input wire                 out_ready,
  input rosf_pkg::out_item_t out_data
);
  import rosf_pkg::*;

  // A pending result holds still until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // No new sample is taken while a result waits.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready while result pending");

  // After the last result of a record the block is free again.
  a_done_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.record_done |=> in_ready && !out_valid)
    else $error("block busy after record end");

  // Reset leaves no result pending.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind running_order_statistic_smoother rosf_checker u_rosf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

// ===== tb/tb_running_order_statistic_smoother.sv =====
// ----------------------------------------------------------------------------
// tb_running_order_statistic_smoother
// Streams records of signed samples through the smoother under several window,
// keep and mode settings, predicts every smoothed beat in the testbench, and
// compares each result beat in order while both sides stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_running_order_statistic_smoother;
  import rosf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The slowest result comes at span 31 in mean mode; this settle time covers any
  // work left in flight after the last expected beat.
  localparam int SETTLE_CYCLES = 300;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int RANDOM_ITEMS  = 480;

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_ready;
  in_item_t                       in_data;
  logic                           out_valid;
  logic                           out_ready;
  out_item_t                      out_data;
  logic                           cfg_we;
  logic [CFG_ADDR_BITS-1:0]       cfg_addr;
  logic [CFG_DATA_BITS-1:0]       cfg_wdata;

  running_order_statistic_smoother uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // Testbench copy of the block's registers and sample history.
  logic [SPAN_BITS-1:0]          span_setting;
  logic [KEEP_BITS-1:0]          keep_setting;
  smooth_mode_t                  mode_setting;
  logic signed [SAMPLE_BITS-1:0] history [WINDOW_DEPTH_DEF];
  int                            record_fill;

  out_item_t pending_smoothed [$];
  int        error_count;
  int        cycle_count;
  int        beats_sent;
  bit        no_idle;
  int        out_stall_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d beats outstanding", $realtime,
               pending_smoothed.size());
      $display("tb_running_order_statistic_smoother failed");
      $finish;
    end
  end

  // Value of the window centred c samples back from the newest sample, using
  // the current span and keep count. Positions outside the record repeat the
  // nearest edge sample.
  function automatic logic signed [SAMPLE_BITS-1:0] window_value(int span, int c);
    int half;
    int n;
    int m;
    int d;
    int v;
    int i;
    int sum;
    int ordered [WINDOW_DEPTH_DEF];
    half = span / 2;
    n    = span + 1;
    m    = keep_setting;
    if (m < 1) m = 1;
    if (m > n) m = n;
    for (int j = 0; j < n; j++) begin
      d = c + half - j;
      if (d < 0) d = 0;
      if (d > record_fill - 1) d = record_fill - 1;
      if (d < 0) d = 0;
      v = history[d];
      i = j;
      while (i > 0 && ordered[i-1] > v) begin
        ordered[i] = ordered[i-1];
        i--;
      end
      ordered[i] = v;
    end
    case (mode_setting)
      MODE_MEDIAN: begin
        // Even counts take the floored mean of the two middle values.
        if (m % 2 == 0) return SAMPLE_BITS'((ordered[m/2-1] + ordered[m/2]) >>> 1);
        return SAMPLE_BITS'(ordered[(m-1)/2]);
      end
      MODE_MEAN: begin
        sum = 0;
        for (int j = 0; j < m; j++) sum += ordered[j];
        return SAMPLE_BITS'(sum / m);
      end
      MODE_MIN: return SAMPLE_BITS'(ordered[0]);
      default:  return SAMPLE_BITS'(ordered[m-1]);
    endcase
  endfunction

  // Update the history with an accepted beat and queue the results it causes.
  task automatic record_accepted(in_item_t beat);
    int span;
    int look;
    int c;
    out_item_t res;
    span = (span_setting == 0) ? 1 : span_setting;
    look = span - span / 2;
    for (int i = WINDOW_DEPTH_DEF - 1; i > 0; i--) history[i] = history[i-1];
    history[0] = beat.sample;
    if (record_fill < WINDOW_DEPTH_DEF) record_fill++;
    if (!beat.final_sample) begin
      if (record_fill - 1 >= look) begin
        res.smoothed    = window_value(span, look);
        res.record_done = 1'b0;
        pending_smoothed.push_back(res);
      end
    end else begin
      // The final beat flushes every position still waiting for look-ahead.
      c = (record_fill - 1 > look) ? look : record_fill - 1;
      while (c >= 0) begin
        res.smoothed    = window_value(span, c);
        res.record_done = (c == 0);
        pending_smoothed.push_back(res);
        c--;
      end
      record_fill = 0;
    end
  endtask

  // Mostly back-to-back or short pauses, now and then a long one.
  function automatic int idle_length();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Send one sample beat; valid stays high into the next beat when no gap
  // follows, so it is only lowered where a gap starts.
  task automatic send_sample(logic signed [SAMPLE_BITS-1:0] value, bit last);
    int gap;
    in_item_t beat;
    gap = idle_length();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    beat.sample       = value;
    beat.final_sample = last;
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    record_accepted(beat);
    beats_sent++;
  endtask

  // Wait until every expected beat has come out and the block has settled.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_smoothed.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The write enable stays high across back-to-back writes; the caller lowers it.
  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      REG_WINDOW_SPAN: span_setting = value[SPAN_BITS-1:0];
      REG_KEEP_COUNT:  keep_setting = value[KEEP_BITS-1:0];
      default:         mode_setting = smooth_mode_t'(value[MODE_BITS-1:0]);
    endcase
  endtask

  task automatic configure(logic [CFG_DATA_BITS-1:0] span, logic [CFG_DATA_BITS-1:0] keep,
                           smooth_mode_t md);
    drain_results();
    write_reg(REG_WINDOW_SPAN, span);
    write_reg(REG_KEEP_COUNT, keep);
    write_reg(REG_MODE, CFG_DATA_BITS'(md));
    cfg_we <= 1'b0;
  endtask

  // Random sample: mostly full range, sometimes at the rails or near zero.
  function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    if (r == 1) return $signed(16'($urandom_range(0, 15)) - 16'd8);
    return SAMPLE_BITS'($urandom);
  endfunction

  // Result side: check each accepted beat against the oldest expectation,
  // then choose the next ready value.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_smoothed.size() == 0) begin
        $display("%0t: unexpected beat smoothed=%0d done=%0b", $realtime,
                 $signed(out_data.smoothed), out_data.record_done);
        error_count++;
      end else begin
        if (out_data.smoothed !== pending_smoothed[0].smoothed) begin
          $display("%0t: smoothed expected %0d actual %0d", $realtime,
                   $signed(pending_smoothed[0].smoothed), $signed(out_data.smoothed));
          error_count++;
        end
        if (out_data.record_done !== pending_smoothed[0].record_done) begin
          $display("%0t: record_done expected %0b actual %0b", $realtime,
                   pending_smoothed[0].record_done, out_data.record_done);
          error_count++;
        end
        void'(pending_smoothed.pop_front());
      end
    end
    if (out_stall_left > 0) begin
      out_ready      <= 1'b0;
      out_stall_left <= out_stall_left - 1;
    end else begin
      out_ready      <= 1'b1;
      out_stall_left <= idle_length();
    end
  end

  // Reset values, extreme samples and a record longer than the window.
  task automatic test_reset_settings();
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'shffff, 1'b0);
    send_sample(16'sh0000, 1'b0);
    send_sample(16'sh0001, 1'b0);
    send_sample(16'sh5555, 1'b0);
    send_sample(16'shaaaa, 1'b1);
  endtask

  // Span zero behaves as span one, keep count zero clamps to one; max, min, median once.
  task automatic test_modes_and_clamps();
    configure(6'd0, 6'd0, MODE_MAX);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(-16'sd3, 1'b1);
    configure(6'd2, 6'd63, MODE_MIN);
    send_sample(16'sd10, 1'b0);
    send_sample(-16'sd7, 1'b0);
    send_sample(16'sd4, 1'b1);
    configure(6'd3, 6'd4, MODE_MEDIAN);
    send_sample(-16'sd5, 1'b0);
    send_sample(16'sd2, 1'b0);
    send_sample(16'sd9, 1'b1);
  endtask

  // Records shorter than the look-ahead at the widest span, in mean mode.
  task automatic test_short_records();
    configure(6'd31, 6'd63, MODE_MEAN);
    send_sample(-16'sd32768, 1'b1);
    send_sample(16'sd32767, 1'b0);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sd100, 1'b1);
  endtask

  // The span changes in the middle of a record while the block is idle.
  task automatic test_span_change_mid_record();
    configure(6'd6, 6'd5, MODE_MEAN);
    for (int i = 0; i < 5; i++) send_sample(random_sample(), 1'b0);
    configure(6'd1, 6'd2, MODE_MEDIAN);
    send_sample(random_sample(), 1'b0);
    send_sample(random_sample(), 1'b1);
  endtask

  // Random records under random settings, extremes of each register included.
  task automatic test_random_records();
    logic [CFG_DATA_BITS-1:0] span;
    logic [CFG_DATA_BITS-1:0] keep;
    int len;
    int start;
    start = beats_sent;
    while (beats_sent - start < RANDOM_ITEMS) begin
      case ($urandom_range(0, 4))
        0:       span = 6'd0;
        1:       span = 6'd31;
        2:       span = 6'd1;
        default: span = CFG_DATA_BITS'($urandom_range(2, 30));
      endcase
      case ($urandom_range(0, 4))
        0:       keep = 6'd0;
        1:       keep = 6'd63;
        2:       keep = 6'd1;
        default: keep = CFG_DATA_BITS'($urandom_range(0, 32));
      endcase
      configure(span, keep, smooth_mode_t'($urandom_range(0, 3)));
      no_idle = ($urandom_range(0, 3) == 0);
      // Most records outlast the look-ahead; some are very short.
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 45);
      for (int i = 1; i <= len; i++) send_sample(random_sample(), i == len);
      no_idle = 1'b0;
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    out_ready      = 1'b0;
    cfg_we         = 1'b0;
    cfg_addr       = REG_WINDOW_SPAN;
    cfg_wdata      = '0;
    cycle_count    = 0;
    error_count    = 0;
    beats_sent     = 0;
    no_idle        = 1'b0;
    out_stall_left = 0;
    span_setting   = SPAN_RESET;
    keep_setting   = KEEP_RESET;
    mode_setting   = MODE_MEDIAN;
    record_fill    = 0;
    for (int i = 0; i < WINDOW_DEPTH_DEF; i++) history[i] = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_settings();
    test_modes_and_clamps();
    test_short_records();
    test_span_change_mid_record();
    test_random_records();
    drain_results();

    if (error_count == 0) begin
      $display("tb_running_order_statistic_smoother passed");
    end else begin
      $display("tb_running_order_statistic_smoother failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/core/rosf_pkg.sv
rtl/core/rosf_cell.sv
rtl/core/rosf_divider.sv
rtl/core/running_order_statistic_smoother.sv
rtl/core/rosf_checker.sv
tb/tb_running_order_statistic_smoother.sv
